// ===== src/cbe_pkg.sv =====
// Shared types and constants of the cubic Bezier easing interpolator.
`default_nettype none
package cbe_pkg;

	localparam int CTRL_X_W = 17;
	localparam int CTRL_Y_W = 18;
	localparam int TIME_W   = 17;
	localparam int ZOOM_W   = 24;
	localparam int CURVE_W  = 18;
	localparam int SIDX_W   = 12;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	// Q0.16 scale of the curve end point (P3 = 1.0) and of the zoom blend
	localparam int X_ONE_SHIFT = 16;
	localparam int ZOOM_FRAC   = 16;

	localparam int CURVE_MAX = 131071;
	localparam int CURVE_MIN = -131072;
	localparam int ZOOM_MAX  = 16777215;

	localparam logic [CTRL_X_W-1:0] X1_RESET = 17'd26214;
	localparam logic [CTRL_Y_W-1:0] Y1_RESET = 18'd0;
	localparam logic [CTRL_X_W-1:0] X2_RESET = 17'd13107;
	localparam logic [CTRL_Y_W-1:0] Y2_RESET = 18'd65536;

	typedef enum logic [1:0] {
		REG_CTRL_X1 = 2'd0,
		REG_CTRL_Y1 = 2'd1,
		REG_CTRL_X2 = 2'd2,
		REG_CTRL_Y2 = 2'd3
	} cbe_reg_t;

endpackage
`default_nettype wire

// ===== src/cbe_bases.sv =====
// Pipelined Bernstein basis evaluator: sample index to b1, b2, b3 in five stages.
`default_nettype none
module cbe_bases #(
	parameter int SEARCH_STEPS  = 4000,
	parameter int FRACTION_BITS = 16,
	parameter int IDX_W         = 12
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [IDX_W-1:0]         idx,
	output logic      [FRACTION_BITS+2:0] b1,
	output logic      [FRACTION_BITS+2:0] b2,
	output logic      [FRACTION_BITS:0]   b3
);
	localparam int F  = FRACTION_BITS;
	localparam int TW = F + 1;
	localparam int BW = F + 3;
	localparam longint unsigned RECIP = (longint'(1) << (IDX_W + F)) / SEARCH_STEPS;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = IDX_W + RW;
	localparam int NW = IDX_W + F;
	localparam int DW = ((PW > NW) ? PW : NW) + 1;
	localparam logic [RW-1:0]    RECIP_R = RW'(RECIP);
	localparam logic [IDX_W-1:0] STEPS_I = IDX_W'(SEARCH_STEPS);
	localparam logic [DW-1:0]    STEPS_D = DW'(SEARCH_STEPS);
	localparam logic [TW-1:0]    ONE     = {1'b1, {F{1'b0}}};

	logic [PW-1:0]    prod_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [RW-1:0]    q_s2;
	logic [DW-1:0]    qs_s2;
	logic [NW-1:0]    n_s2;
	logic [TW-1:0]    t_s3, u_s3;
	logic [TW-1:0]    t_s4, u_s4, uu_s4, tt_s4;
	logic [DW-1:0]    rem, tq;
	logic [TW-1:0]    t_c;
	logic [2*TW-1:0]  sq_u, sq_t, m1, m2, m3;
	logic [RW-1:0]    q_c;

	// index * 2^F / steps by reciprocal, one correction step
	assign q_c = prod_s1[PW-1 -: RW];
	assign rem = DW'(n_s2) - qs_s2;
	always_comb begin
		tq = DW'(q_s2) + DW'(rem >= STEPS_D);
		if (tq > DW'(ONE)) begin
			t_c = ONE;
		end else begin
			t_c = tq[TW-1:0];
		end
	end

	assign sq_u = (2*TW)'(u_s3) * (2*TW)'(u_s3);
	assign sq_t = (2*TW)'(t_s3) * (2*TW)'(t_s3);
	assign m1   = (2*TW)'(uu_s4) * (2*TW)'(t_s4);
	assign m2   = (2*TW)'(tt_s4) * (2*TW)'(u_s4);
	assign m3   = (2*TW)'(tt_s4) * (2*TW)'(t_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(idx) * PW'(RECIP_R);
			idx_s1  <= idx;
			q_s2    <= q_c;
			qs_s2   <= DW'(q_c) * DW'(STEPS_I);
			n_s2    <= {idx_s1, {F{1'b0}}};
			t_s3    <= t_c;
			u_s3    <= ONE - t_c;
			uu_s4   <= sq_u[F +: TW];
			tt_s4   <= sq_t[F +: TW];
			t_s4    <= t_s3;
			u_s4    <= u_s3;
			b1      <= BW'(m1[F +: TW]) + (BW'(m1[F +: TW]) << 1);
			b2      <= BW'(m2[F +: TW]) + (BW'(m2[F +: TW]) << 1);
			b3      <= m3[F +: TW];
		end
	end
endmodule
`default_nettype wire

// ===== src/cbe_search_step.sv =====
// One binary search step: curve X at the midpoint, compare, narrow the bounds.
`default_nettype none
module cbe_search_step #(
	parameter int SEARCH_STEPS  = 4000,
	parameter int FRACTION_BITS = 16,
	parameter int IDX_W         = 12,
	parameter int PASS_W        = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [cbe_pkg::CTRL_X_W-1:0]  ctrl_x1,
	input  wire logic [cbe_pkg::CTRL_X_W-1:0]  ctrl_x2,
	input  wire logic                          cur_valid,
	input  wire logic [cbe_pkg::TIME_W-1:0]    cur_tfrac,
	input  wire logic signed [IDX_W:0]         cur_low,
	input  wire logic signed [IDX_W:0]         cur_high,
	input  wire logic                          cur_done,
	input  wire logic [IDX_W-1:0]              cur_fidx,
	input  wire logic [PASS_W-1:0]             cur_pass,
	output logic                               nxt_valid,
	output logic [cbe_pkg::TIME_W-1:0]         nxt_tfrac,
	output logic signed [IDX_W:0]              nxt_low,
	output logic signed [IDX_W:0]              nxt_high,
	output logic                               nxt_done,
	output logic [IDX_W-1:0]                   nxt_fidx,
	output logic [PASS_W-1:0]                  nxt_pass
);
	import cbe_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int TW  = F + 1;
	localparam int BW  = F + 3;
	localparam int LW  = IDX_W + 1;
	localparam int XW  = BW + CTRL_X_W + 2;
	localparam int DEP = 6;

	logic                 vld_s [DEP];
	logic [TIME_W-1:0]    tf_s  [DEP];
	logic signed [LW-1:0] lo_s  [DEP];
	logic signed [LW-1:0] hi_s  [DEP];
	logic [IDX_W-1:0]     mid_s [DEP];
	logic                 dn_s  [DEP];
	logic [IDX_W-1:0]     fi_s  [DEP];
	logic                 act_s [DEP];
	logic [PASS_W-1:0]    ps_s  [DEP];

	logic signed [LW:0]   sum;
	logic [IDX_W-1:0]     mid;
	logic                 act;
	logic [BW-1:0]        b1, b2;
	logic [TW-1:0]        b3;
	logic [BW+CTRL_X_W-1:0] px1_s6, px2_s6;
	logic [TW-1:0]        pb3_s6;
	logic [XW-1:0]        x, tgt;
	logic [IDX_W-1:0]     mid_f;
	logic signed [LW-1:0] mid_x;

	assign sum = {cur_low[LW-1], cur_low} + {cur_high[LW-1], cur_high};
	assign mid = sum[IDX_W:1];
	assign act = !cur_done && (cur_low <= cur_high);

	cbe_bases #(
		.SEARCH_STEPS (SEARCH_STEPS),
		.FRACTION_BITS(FRACTION_BITS),
		.IDX_W        (IDX_W)
	) u_bases (
		.clk(clk),
		.en (en),
		.idx(mid),
		.b1 (b1),
		.b2 (b2),
		.b3 (b3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEP; k++) vld_s[k] <= 1'b0;
			nxt_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= cur_valid;
			for (int k = 1; k < DEP; k++) vld_s[k] <= vld_s[k-1];
			nxt_valid <= vld_s[DEP-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tf_s[0]  <= cur_tfrac;
			lo_s[0]  <= cur_low;
			hi_s[0]  <= cur_high;
			mid_s[0] <= mid;
			dn_s[0]  <= cur_done;
			fi_s[0]  <= cur_fidx;
			act_s[0] <= act;
			ps_s[0]  <= cur_pass;
			for (int k = 1; k < DEP; k++) begin
				tf_s[k]  <= tf_s[k-1];
				lo_s[k]  <= lo_s[k-1];
				hi_s[k]  <= hi_s[k-1];
				mid_s[k] <= mid_s[k-1];
				dn_s[k]  <= dn_s[k-1];
				fi_s[k]  <= fi_s[k-1];
				act_s[k] <= act_s[k-1];
				ps_s[k]  <= ps_s[k-1];
			end
			px1_s6 <= (BW+CTRL_X_W)'(b1) * (BW+CTRL_X_W)'(ctrl_x1);
			px2_s6 <= (BW+CTRL_X_W)'(b2) * (BW+CTRL_X_W)'(ctrl_x2);
			pb3_s6 <= b3;
		end
	end

	assign x     = XW'(px1_s6) + XW'(px2_s6) + (XW'(pb3_s6) << X_ONE_SHIFT);
	assign tgt   = XW'(tf_s[DEP-1]) << F;
	assign mid_f = mid_s[DEP-1];
	assign mid_x = $signed({1'b0, mid_f});

	always_ff @(posedge clk) begin
		if (en) begin
			nxt_tfrac <= tf_s[DEP-1];
			nxt_pass  <= ps_s[DEP-1];
			nxt_low   <= lo_s[DEP-1];
			nxt_high  <= hi_s[DEP-1];
			nxt_done  <= dn_s[DEP-1];
			nxt_fidx  <= fi_s[DEP-1];
			if (act_s[DEP-1]) begin
				priority if (x < tgt) begin
					nxt_low <= mid_x + LW'(1);
				end else if (x > tgt) begin
					nxt_high <= mid_x - LW'(1);
				end else begin
					nxt_done <= 1'b1;
					nxt_fidx <= mid_f;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/cubic_bezier_easing_interpolator_core.sv =====
// Top level of the cubic Bezier easing interpolator: config registers, search chain, blend.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------
//  in      | in_valid / in_stall        | time_fraction, start_zoom, end_zoom
//  out     | out_valid / out_stall      | eased_zoom, curve_value, search_index
//  cfg     | APB psel/penable/pwrite    | ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2
//
// One request enters per cycle while in_stall is low; it passes clog2(SEARCH_STEPS+2) search
// steps, then the curve Y and blend stages.
// Throughput is set by the fully unrolled search chain: every step owns its multipliers.
// Reset clears the valid bits and loads the control point defaults.
// A stalled result freezes the whole pipeline, so nothing is dropped or repeated.
`default_nettype none
module cubic_bezier_easing_interpolator_core #(
	parameter int SEARCH_STEPS  = 4000,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cbe_pkg::APB_AW-1:0]    paddr,
	input  wire logic [cbe_pkg::APB_DW-1:0]    pwdata,
	output logic      [cbe_pkg::APB_DW-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [cbe_pkg::TIME_W-1:0]    time_fraction,
	input  wire logic [cbe_pkg::ZOOM_W-1:0]    start_zoom,
	input  wire logic [cbe_pkg::ZOOM_W-1:0]    end_zoom,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [cbe_pkg::ZOOM_W-1:0]         eased_zoom,
	output logic signed [cbe_pkg::CURVE_W-1:0] curve_value,
	output logic [cbe_pkg::SIDX_W-1:0]         search_index
);
	import cbe_pkg::*;

	localparam int F      = FRACTION_BITS;
	localparam int TW     = F + 1;
	localparam int BW     = F + 3;
	localparam int IW     = $clog2(SEARCH_STEPS + 2);
	localparam int NIT    = IW;
	localparam int LW     = IW + 1;
	localparam int PASS_W = 2 * ZOOM_W;
	localparam int PYW    = BW + 1 + CTRL_Y_W;
	localparam int YW     = PYW + 2;
	localparam int DIFF_W = ZOOM_W + 1;
	localparam int ZPW    = DIFF_W + CURVE_W;
	localparam int ZSW    = ZOOM_W + 5;
	localparam int EDEP   = 6;
	localparam logic [IW-1:0]       STEPS_I = IW'(SEARCH_STEPS);
	localparam logic signed [YW-1:0] YMAX   = YW'(CURVE_MAX);
	localparam logic signed [YW-1:0] YMIN   = YW'(CURVE_MIN);
	localparam logic signed [ZSW-1:0] ZMAX  = ZSW'(ZOOM_MAX);

	// ---------------- configuration registers ----------------
	logic [CTRL_X_W-1:0]        ctrl_x1_q, ctrl_x2_q;
	logic signed [CTRL_Y_W-1:0] ctrl_y1_q, ctrl_y2_q;
	logic                       wr_en;
	cbe_reg_t                   reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = cbe_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_x1_q <= X1_RESET;
			ctrl_y1_q <= Y1_RESET;
			ctrl_x2_q <= X2_RESET;
			ctrl_y2_q <= Y2_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CTRL_X1: ctrl_x1_q <= pwdata[CTRL_X_W-1:0];
				REG_CTRL_Y1: ctrl_y1_q <= pwdata[CTRL_Y_W-1:0];
				REG_CTRL_X2: ctrl_x2_q <= pwdata[CTRL_X_W-1:0];
				REG_CTRL_Y2: ctrl_y2_q <= pwdata[CTRL_Y_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CTRL_X1: prdata = APB_DW'(ctrl_x1_q);
			REG_CTRL_Y1: prdata = APB_DW'($unsigned(ctrl_y1_q));
			REG_CTRL_X2: prdata = APB_DW'(ctrl_x2_q);
			REG_CTRL_Y2: prdata = APB_DW'($unsigned(ctrl_y2_q));
			default:     prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// whole pipe advances unless a finished result is held by the sink
	logic adv;
	assign in_stall = out_valid && out_stall;
	assign adv      = !in_stall;

	// ---------------- search chain ----------------
	logic                 ch_vld  [NIT+1];
	logic [TIME_W-1:0]    ch_tf   [NIT+1];
	logic signed [LW-1:0] ch_lo   [NIT+1];
	logic signed [LW-1:0] ch_hi   [NIT+1];
	logic                 ch_dn   [NIT+1];
	logic [IW-1:0]        ch_fi   [NIT+1];
	logic [PASS_W-1:0]    ch_ps   [NIT+1];

	assign ch_vld[0] = in_valid;
	assign ch_tf[0]  = time_fraction;
	assign ch_lo[0]  = '0;
	assign ch_hi[0]  = $signed({1'b0, STEPS_I});
	assign ch_dn[0]  = 1'b0;
	assign ch_fi[0]  = '0;
	assign ch_ps[0]  = {start_zoom, end_zoom};

	for (genvar g = 0; g < NIT; g++) begin : g_step
		cbe_search_step #(
			.SEARCH_STEPS (SEARCH_STEPS),
			.FRACTION_BITS(FRACTION_BITS),
			.IDX_W        (IW),
			.PASS_W       (PASS_W)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctrl_x1  (ctrl_x1_q),
			.ctrl_x2  (ctrl_x2_q),
			.cur_valid(ch_vld[g]),
			.cur_tfrac(ch_tf[g]),
			.cur_low  (ch_lo[g]),
			.cur_high (ch_hi[g]),
			.cur_done (ch_dn[g]),
			.cur_fidx (ch_fi[g]),
			.cur_pass (ch_ps[g]),
			.nxt_valid(ch_vld[g+1]),
			.nxt_tfrac(ch_tf[g+1]),
			.nxt_low  (ch_lo[g+1]),
			.nxt_high (ch_hi[g+1]),
			.nxt_done (ch_dn[g+1]),
			.nxt_fidx (ch_fi[g+1]),
			.nxt_pass (ch_ps[g+1])
		);
	end

	// exact hit wins, else the low bound; the curve is evaluated at most at t = 1.0
	logic [IW-1:0] found, eval_idx;
	logic [PASS_W-1:0] pass_end;
	logic signed [DIFF_W-1:0] diff;
	assign found    = ch_dn[NIT] ? ch_fi[NIT] : ch_lo[NIT][IW-1:0];
	assign eval_idx = (found > STEPS_I) ? STEPS_I : found;
	assign pass_end = ch_ps[NIT];
	assign diff     = $signed({1'b0, pass_end[ZOOM_W-1:0]})
	                - $signed({1'b0, pass_end[PASS_W-1 -: ZOOM_W]});

	// ---------------- curve Y ----------------
	logic [BW-1:0] eb1, eb2;
	logic [TW-1:0] eb3;

	cbe_bases #(
		.SEARCH_STEPS (SEARCH_STEPS),
		.FRACTION_BITS(FRACTION_BITS),
		.IDX_W        (IW)
	) u_eval_bases (
		.clk(clk),
		.en (adv),
		.idx(eval_idx),
		.b1 (eb1),
		.b2 (eb2),
		.b3 (eb3)
	);

	logic                     ev_vld [EDEP];
	logic [IW-1:0]            ev_fnd [EDEP];
	logic [ZOOM_W-1:0]        ev_st  [EDEP];
	logic signed [DIFF_W-1:0] ev_df  [EDEP];
	logic signed [PYW-1:0]    py1_s6, py2_s6;
	logic [TW-1:0]            pb3_s6;

	logic                     vld_s7, vld_s8;
	logic [IW-1:0]            fnd_s7, fnd_s8;
	logic [ZOOM_W-1:0]        st_s7, st_s8;
	logic signed [DIFF_W-1:0] df_s7;
	logic signed [CURVE_W-1:0] cv_s7, cv_s8;
	logic signed [ZPW-1:0]    zp_s8;

	logic signed [YW-1:0]     ysum, yfl;
	logic signed [CURVE_W-1:0] ysat;
	logic signed [ZPW-1:0]    zsh;
	logic signed [ZSW-1:0]    zsum;
	logic [ZOOM_W-1:0]        zsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < EDEP; k++) ev_vld[k] <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			ev_vld[0] <= ch_vld[NIT];
			for (int k = 1; k < EDEP; k++) ev_vld[k] <= ev_vld[k-1];
			vld_s7    <= ev_vld[EDEP-1];
			vld_s8    <= vld_s7;
			out_valid <= vld_s8;
		end
	end

	// Y = floor(sum / 2^F), saturated to the Q2.16 range
	assign ysum = YW'(py1_s6) + YW'(py2_s6) + $signed(YW'(pb3_s6) << X_ONE_SHIFT);
	assign yfl  = ysum >>> F;
	always_comb begin
		priority if (yfl > YMAX) begin
			ysat = CURVE_W'(YMAX);
		end else if (yfl < YMIN) begin
			ysat = CURVE_W'(YMIN);
		end else begin
			ysat = yfl[CURVE_W-1:0];
		end
	end

	// zoom = start + floor((end - start) * Y / 2^16), clamped to the zoom range
	assign zsh  = zp_s8 >>> ZOOM_FRAC;
	assign zsum = $signed({{(ZSW-ZOOM_W){1'b0}}, st_s8}) + ZSW'(zsh);
	always_comb begin
		priority if (zsum < 0) begin
			zsat = '0;
		end else if (zsum > ZMAX) begin
			zsat = ZOOM_W'(ZMAX);
		end else begin
			zsat = zsum[ZOOM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_fnd[0] <= found;
			ev_st[0]  <= pass_end[PASS_W-1 -: ZOOM_W];
			ev_df[0]  <= diff;
			for (int k = 1; k < EDEP; k++) begin
				ev_fnd[k] <= ev_fnd[k-1];
				ev_st[k]  <= ev_st[k-1];
				ev_df[k]  <= ev_df[k-1];
			end
			py1_s6 <= $signed({1'b0, eb1}) * ctrl_y1_q;
			py2_s6 <= $signed({1'b0, eb2}) * ctrl_y2_q;
			pb3_s6 <= eb3;

			fnd_s7 <= ev_fnd[EDEP-1];
			st_s7  <= ev_st[EDEP-1];
			df_s7  <= ev_df[EDEP-1];
			cv_s7  <= ysat;

			fnd_s8 <= fnd_s7;
			st_s8  <= st_s7;
			cv_s8  <= cv_s7;
			zp_s8  <= df_s7 * cv_s7;

			eased_zoom   <= zsat;
			curve_value  <= cv_s8;
			search_index <= SIDX_W'(fnd_s8);
		end
	end
endmodule
`default_nettype wire
